>>> src/sen_pkg.sv
// Shared types, widths and constants of the sample effect and note sequencer.
package sen_pkg;

  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 14;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 15;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 15;
  localparam int REP_W    = 16;
  localparam int PERIOD_W = 25;
  localparam int NCOUNT_W = 7;
  localparam int DAC_W    = 12;
  localparam int RELOAD_W = 24;

  localparam int SAMPLE_DEPTH_DEF = 16384;
  localparam int NOTE_DEPTH_DEF   = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int RES_DEPTH        = 2;

  localparam logic [DAC_W-1:0]    SILENCE      = 12'd2048;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 24'd7271;
  localparam logic [RELOAD_W-1:0] RELOAD_MAX   = 24'hFFFFFF;

  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_SAMPLE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_NOTE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EFFECT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUSIC     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_WR_SAMPLE,
    OP_WR_NOTE,
    OP_EFFECT,
    OP_MUSIC,
    OP_STOP
  } op_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_RELOAD,
    ST_NOTE
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [ADDR_W-1:0]    sample_address;
    logic [BYTE_W-1:0]    sample_byte;
    logic [COUNT_W-1:0]   play_count;
    logic [IDX_W-1:0]     note_index;
    logic [ADDR_W-1:0]    note_start;
    logic [LEN_W-1:0]     note_length;
    logic [REP_W-1:0]     note_repeats;
    logic [RELOAD_W-1:0]  note_reload;
    logic [NCOUNT_W-1:0]  note_count;
  } item_t;

endpackage

>>> src/sen_in_if.sv
// Command channel interface of the sequencer.
interface sen_in_if import sen_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ADDR_W-1:0]    sample_address;
  logic [BYTE_W-1:0]    sample_byte;
  logic [COUNT_W-1:0]   play_count;
  logic [IDX_W-1:0]     note_index;
  logic [ADDR_W-1:0]    note_start;
  logic [LEN_W-1:0]     note_length;
  logic [REP_W-1:0]     note_repeats;
  logic [PERIOD_W-1:0]  note_period;
  logic [NCOUNT_W-1:0]  note_count;

  modport source (
    output valid, cmd, sample_address, sample_byte, play_count, note_index,
           note_start, note_length, note_repeats, note_period, note_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample_address, sample_byte, play_count, note_index,
           note_start, note_length, note_repeats, note_period, note_count,
    output ready
  );
endinterface

>>> src/sen_out_if.sv
// Result channel interface of the sequencer.
interface sen_out_if import sen_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DAC_W-1:0]     dac_value;
  logic [RELOAD_W-1:0]  timer_reload;

  modport source (output valid, dac_value, timer_reload, input ready);
  modport sink (input valid, dac_value, timer_reload, output ready);
endinterface

>>> src/sample_effect_and_note_sequencer_top.sv
// Top level of the sample effect and note sequencer.
//
//   Channel   Direction  Handshake      Carries
//   in_chan   input      valid/ready    one command: tick, write, effect, music, stop
//   out_chan  output     valid/ready    one DAC value and timer reload per tick
//
// A tick that ends a pass that repeats passes through the reload state, and a tick
// that moves on to the next note passes through the note state, as does start music.
// The note table read before the sample read is what needs these extra states.
// A result is held in the sample read register and then in the result buffer before it leaves.
// Reset is synchronous and active low; the memories are not cleared.
// A two-entry command queue and a two-entry result buffer let either side stall alone.
module sample_effect_and_note_sequencer_top import sen_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int NOTE_DEPTH   = NOTE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sen_in_if.sink    in_chan,
  sen_out_if.source out_chan
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  q_valid, q_ready;
  item_t q_item;

  sen_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sen_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  sen_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .NOTE_DEPTH   (NOTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_dac    (out_chan.dac_value),
    .out_reload (out_chan.timer_reload)
  );

endmodule

>>> src/sen_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/sen_front.sv
// Front end: accepts commands, drops ignored ones and normalizes note fields.
module sen_front import sen_pkg::*; (
  sen_in_if.sink  in_chan,
  output logic    push_valid,
  input  logic    push_ready,
  output item_t   push_item
);

  logic                keep;
  logic [PERIOD_W-1:0] period_m1;

  assign period_m1 = in_chan.note_period - PERIOD_W'(1);

  always_comb begin
    keep = 1'b1;
    push_item.op = OP_TICK;
    unique case (in_chan.cmd)
      CMD_TICK:      push_item.op = OP_TICK;
      CMD_WR_SAMPLE: push_item.op = OP_WR_SAMPLE;
      CMD_WR_NOTE:   push_item.op = OP_WR_NOTE;
      CMD_EFFECT:    push_item.op = OP_EFFECT;
      CMD_MUSIC: begin
        push_item.op = OP_MUSIC;
        keep = (in_chan.note_count != '0);
      end
      CMD_STOP:      push_item.op = OP_STOP;
      default:       keep = 1'b0;
    endcase

    push_item.sample_address = in_chan.sample_address;
    push_item.sample_byte    = in_chan.sample_byte;
    push_item.play_count     = in_chan.play_count;
    push_item.note_index     = in_chan.note_index;
    push_item.note_start     = in_chan.note_start;
    push_item.note_length    = (in_chan.note_length == '0) ? LEN_W'(1) : in_chan.note_length;
    push_item.note_repeats   = in_chan.note_repeats;
    push_item.note_count     = in_chan.note_count;

    if (in_chan.note_period == '0) begin
      push_item.note_reload = '0;
    end else if (in_chan.note_period[PERIOD_W-1] &&
                 (in_chan.note_period[RELOAD_W-1:0] != '0)) begin
      push_item.note_reload = RELOAD_MAX;
    end else begin
      push_item.note_reload = period_m1[RELOAD_W-1:0];
    end
  end

  assign push_valid    = in_chan.valid && keep;
  assign in_chan.ready = push_ready;

endmodule

>>> src/sen_fifo.sv
// Short command queue between the front end and the back end.
module sen_fifo import sen_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign push_ready = (32'(count_r) < QUEUE_DEPTH);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

>>> src/sen_back.sv
// Back end: executes commands against sample and note memories and buffers results.
module sen_back import sen_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int NOTE_DEPTH   = NOTE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  item_t               q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DAC_W-1:0]    out_dac,
  output logic [RELOAD_W-1:0] out_reload
);

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int NW  = $clog2(NOTE_DEPTH);
  localparam int LW  = $clog2(NOTE_DEPTH + 1);
  localparam int NEW = AW + LEN_W + REP_W + RELOAD_W;
  localparam int RPW = $clog2(RES_DEPTH);
  localparam int RCW = $clog2(RES_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       play_addr_r, play_addr_nxt;
  logic [LEN_W-1:0]    samples_left_r, samples_left_nxt;
  logic [NW-1:0]       music_pos_r, music_pos_nxt;
  logic [LW-1:0]       music_len_r, music_len_nxt;
  logic                music_on_r, music_on_nxt;
  logic                effect_on_r, effect_on_nxt;
  logic [REP_W-1:0]    passes_left_r, passes_left_nxt;
  logic [RELOAD_W-1:0] reload_r, reload_nxt;
  logic [NW-1:0]       ld_pos_r, ld_pos_nxt;
  logic                ld_emit_r, ld_emit_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_sil_r, pend_sil_nxt;
  logic [RELOAD_W-1:0] pend_reload_r, pend_reload_nxt;

  logic                s_we;
  logic [AW-1:0]       s_waddr, s_raddr;
  logic [BYTE_W-1:0]   s_rdata;
  logic                n_we;
  logic [NW-1:0]       n_waddr, n_raddr;
  logic [NEW-1:0]      n_wdata, n_rdata;

  logic [AW-1:0]       nr_start;
  logic [LEN_W-1:0]    nr_len;
  logic [REP_W-1:0]    nr_rep;
  logic [RELOAD_W-1:0] nr_reload;

  logic [AW-1:0]       play_inc, start_inc;
  logic [LEN_W-1:0]    sl_dec;
  logic [NW-1:0]       next_pos;
  logic                room;

  logic [DAC_W-1:0]    res_dac_r [RES_DEPTH];
  logic [RELOAD_W-1:0] res_rel_r [RES_DEPTH];
  logic [RPW-1:0]      res_wr_r, res_rd_r;
  logic [RCW-1:0]      res_cnt_r;
  logic                res_pop;
  logic [DAC_W-1:0]    push_dac;

  sen_ram #(.WIDTH(BYTE_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_data (q_item.sample_byte),
    .rd_addr (s_raddr),
    .rd_data (s_rdata)
  );

  sen_ram #(.WIDTH(NEW), .DEPTH(NOTE_DEPTH)) u_note_ram (
    .clk     (clk),
    .wr_en   (n_we),
    .wr_addr (n_waddr),
    .wr_data (n_wdata),
    .rd_addr (n_raddr),
    .rd_data (n_rdata)
  );

  assign nr_start  = n_rdata[NEW-1 -: AW];
  assign nr_len    = n_rdata[LEN_W+REP_W+RELOAD_W-1 -: LEN_W];
  assign nr_rep    = n_rdata[REP_W+RELOAD_W-1 -: REP_W];
  assign nr_reload = n_rdata[RELOAD_W-1:0];

  assign play_inc  = (32'(play_addr_r) + 1 == SAMPLE_DEPTH) ? '0 : play_addr_r + AW'(1);
  assign start_inc = (32'(nr_start) + 1 == SAMPLE_DEPTH) ? '0 : nr_start + AW'(1);
  assign sl_dec    = samples_left_r - LEN_W'(1);
  assign next_pos  = (32'(music_pos_r) + 1 == 32'(music_len_r)) ? '0 : music_pos_r + NW'(1);

  assign res_pop   = (res_cnt_r != '0) && out_ready;
  assign room      = (32'(res_cnt_r) + 32'(pend_r)) < (RES_DEPTH + 32'(res_pop));

  always_comb begin
    state_nxt        = state_r;
    play_addr_nxt    = play_addr_r;
    samples_left_nxt = samples_left_r;
    music_pos_nxt    = music_pos_r;
    music_len_nxt    = music_len_r;
    music_on_nxt     = music_on_r;
    effect_on_nxt    = effect_on_r;
    passes_left_nxt  = passes_left_r;
    reload_nxt       = reload_r;
    ld_pos_nxt       = ld_pos_r;
    ld_emit_nxt      = ld_emit_r;
    pend_nxt         = 1'b0;
    pend_sil_nxt     = 1'b0;
    pend_reload_nxt  = reload_r;
    q_ready          = 1'b0;
    s_we             = 1'b0;
    s_waddr          = AW'(q_item.sample_address);
    s_raddr          = play_addr_r;
    n_we             = 1'b0;
    n_waddr          = NW'(q_item.note_index);
    n_wdata          = {AW'(q_item.note_start), q_item.note_length,
                        q_item.note_repeats, q_item.note_reload};
    n_raddr          = music_pos_r;

    unique case (state_r)
      ST_EXEC: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_TICK: begin
              if (room) begin
                q_ready = 1'b1;
                if (samples_left_r != '0) begin
                  pend_nxt         = 1'b1;
                  play_addr_nxt    = play_inc;
                  samples_left_nxt = sl_dec;
                  if ((sl_dec == '0) && music_on_r && !effect_on_r &&
                      (passes_left_r > REP_W'(1))) begin
                    state_nxt = ST_RELOAD;
                  end
                end else if (music_on_r) begin
                  effect_on_nxt = 1'b0;
                  n_raddr       = next_pos;
                  ld_pos_nxt    = next_pos;
                  ld_emit_nxt   = 1'b1;
                  state_nxt     = ST_NOTE;
                end else begin
                  pend_nxt     = 1'b1;
                  pend_sil_nxt = 1'b1;
                end
              end
            end
            OP_WR_SAMPLE: begin
              q_ready = 1'b1;
              s_we    = 1'b1;
            end
            OP_WR_NOTE: begin
              q_ready = 1'b1;
              n_we    = 1'b1;
            end
            OP_EFFECT: begin
              q_ready          = 1'b1;
              effect_on_nxt    = 1'b1;
              play_addr_nxt    = AW'(q_item.sample_address);
              samples_left_nxt = q_item.play_count;
            end
            OP_MUSIC: begin
              q_ready       = 1'b1;
              music_len_nxt = (32'(q_item.note_count) > NOTE_DEPTH) ?
                              LW'(NOTE_DEPTH) : LW'(q_item.note_count);
              music_on_nxt  = 1'b1;
              effect_on_nxt = 1'b0;
              n_raddr       = '0;
              ld_pos_nxt    = '0;
              ld_emit_nxt   = 1'b0;
              state_nxt     = ST_NOTE;
            end
            OP_STOP: begin
              q_ready      = 1'b1;
              music_on_nxt = 1'b0;
            end
            default: q_ready = 1'b1;
          endcase
        end
      end
      ST_RELOAD: begin
        passes_left_nxt  = passes_left_r - REP_W'(1);
        play_addr_nxt    = nr_start;
        samples_left_nxt = nr_len;
        state_nxt        = ST_EXEC;
      end
      ST_NOTE: begin
        music_pos_nxt   = ld_pos_r;
        passes_left_nxt = nr_rep;
        reload_nxt      = nr_reload;
        if (ld_emit_r) begin
          s_raddr          = nr_start;
          play_addr_nxt    = start_inc;
          samples_left_nxt = (nr_len != '0) ? nr_len - LEN_W'(1) : '0;
          pend_nxt         = 1'b1;
          pend_reload_nxt  = nr_reload;
        end else begin
          play_addr_nxt    = nr_start;
          samples_left_nxt = nr_len;
        end
        state_nxt = ST_EXEC;
      end
      default: state_nxt = ST_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_EXEC;
      play_addr_r    <= '0;
      samples_left_r <= '0;
      music_pos_r    <= '0;
      music_len_r    <= LW'(1);
      music_on_r     <= 1'b0;
      effect_on_r    <= 1'b0;
      passes_left_r  <= '0;
      reload_r       <= RELOAD_RESET;
      ld_pos_r       <= '0;
      ld_emit_r      <= 1'b0;
      pend_r         <= 1'b0;
      pend_sil_r     <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      play_addr_r    <= play_addr_nxt;
      samples_left_r <= samples_left_nxt;
      music_pos_r    <= music_pos_nxt;
      music_len_r    <= music_len_nxt;
      music_on_r     <= music_on_nxt;
      effect_on_r    <= effect_on_nxt;
      passes_left_r  <= passes_left_nxt;
      reload_r       <= reload_nxt;
      ld_pos_r       <= ld_pos_nxt;
      ld_emit_r      <= ld_emit_nxt;
      pend_r         <= pend_nxt;
      pend_sil_r     <= pend_sil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_reload_r <= pend_reload_nxt;
  end

  // The sample read issued last cycle lands here and enters the result buffer.
  assign push_dac = pend_sil_r ? SILENCE : {s_rdata, 4'b0000};

  always_ff @(posedge clk) begin
    if (pend_r) begin
      res_dac_r[res_wr_r] <= push_dac;
      res_rel_r[res_wr_r] <= pend_reload_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (pend_r) begin
        res_wr_r <= (32'(res_wr_r) == RES_DEPTH - 1) ? '0 : res_wr_r + RPW'(1);
      end
      if (res_pop) begin
        res_rd_r <= (32'(res_rd_r) == RES_DEPTH - 1) ? '0 : res_rd_r + RPW'(1);
      end
      res_cnt_r <= res_cnt_r + RCW'(pend_r) - RCW'(res_pop);
    end
  end

  assign out_valid  = (res_cnt_r != '0);
  assign out_dac    = res_dac_r[res_rd_r];
  assign out_reload = res_rel_r[res_rd_r];

endmodule

>>> src/sen_checker.sv
// Port-level checker for the sequencer top level and its bind.
module sen_checker import sen_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [CMD_W-1:0]    in_cmd,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DAC_W-1:0]    out_dac_value,
  input logic [RELOAD_W-1:0] out_timer_reload
);

  logic [3:0] owed_r;
  logic       tick_in, res_out;

  assign tick_in = in_valid && in_ready && (in_cmd == CMD_TICK);
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else begin
      owed_r <= owed_r + 4'(tick_in) - 4'(res_out);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_value) &&
                                $stable(out_timer_reload))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  a_dac_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dac_value[3:0] == 4'd0))
    else $error("DAC value has nonzero low bits");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    res_out |-> (owed_r != '0))
    else $error("result transfer without an earlier tick");

endmodule

bind sample_effect_and_note_sequencer_top sen_checker u_sen_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_cmd           (in_chan.cmd),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_dac_value    (out_chan.dac_value),
  .out_timer_reload (out_chan.timer_reload)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

// Self-checking testbench for the sample effect and note sequencer: directed table, then random traffic.
module tb;
  import sen_pkg::*;

  localparam int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF;
  localparam int NOTE_DEPTH   = NOTE_DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 48;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   sample_address;
    logic [BYTE_W-1:0]   sample_byte;
    logic [COUNT_W-1:0]  play_count;
    logic [IDX_W-1:0]    note_index;
    logic [ADDR_W-1:0]   note_start;
    logic [LEN_W-1:0]    note_length;
    logic [REP_W-1:0]    note_repeats;
    logic [PERIOD_W-1:0] note_period;
    logic [NCOUNT_W-1:0] note_count;
    bit                  pinned;
    logic [DAC_W-1:0]    dac;
    logic [RELOAD_W-1:0] reload;
  } seq_row_t;

  typedef struct {
    logic [DAC_W-1:0]    dac;
    logic [RELOAD_W-1:0] reload;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sen_in_if  in_chan ();
  sen_out_if out_chan ();

  sample_effect_and_note_sequencer_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #10 clk = ~clk;

  logic [BYTE_W-1:0]   sample_mem [SAMPLE_DEPTH];
  bit                  sample_known [SAMPLE_DEPTH];
  logic [ADDR_W-1:0]   note_start_mem [NOTE_DEPTH];
  logic [LEN_W-1:0]    note_len_mem [NOTE_DEPTH];
  logic [REP_W-1:0]    note_rep_mem [NOTE_DEPTH];
  logic [RELOAD_W-1:0] note_reload_mem [NOTE_DEPTH];
  bit                  note_known [NOTE_DEPTH];

  logic [ADDR_W-1:0]   play_addr  = '0;
  logic [LEN_W-1:0]    left_cnt   = '0;
  logic [IDX_W-1:0]    note_pos   = '0;
  logic [NCOUNT_W-1:0] seq_len    = 7'd1;
  bit                  music_on   = 1'b0;
  bit                  effect_on  = 1'b0;
  logic [REP_W-1:0]    passes     = '0;
  logic [RELOAD_W-1:0] cur_reload = RELOAD_RESET;

  tick_out_t pending_ticks [$];

  int cmd_tally [8];
  int useful_cnt     = 0;
  int ignored_cnt    = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycle_cnt      = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  function automatic logic [DAC_W-1:0] pull_sample();
    logic [DAC_W-1:0] v;
    v = {sample_mem[play_addr], 4'h0};
    play_addr = ADDR_W'((int'(play_addr) + 1) % SAMPLE_DEPTH);
    if (left_cnt != 0) left_cnt = left_cnt - 1'b1;
    return v;
  endfunction

  function automatic void enter_note(input int p);
    p = p % NOTE_DEPTH;
    note_pos   = IDX_W'(p);
    passes     = note_rep_mem[p];
    play_addr  = note_start_mem[p];
    left_cnt   = note_len_mem[p];
    cur_reload = note_reload_mem[p];
  endfunction

  // Applies one command to the sequencer state; returns 1 when it yields a tick result.
  function automatic bit play_step(input seq_row_t c, output tick_out_t o);
    int idx;
    bit emits;
    emits = 1'b0;
    o.dac = SILENCE;
    o.reload = cur_reload;
    case (c.cmd)
      CMD_WR_SAMPLE: begin
        idx = int'(c.sample_address) % SAMPLE_DEPTH;
        sample_mem[idx] = c.sample_byte;
        sample_known[idx] = 1'b1;
      end
      CMD_WR_NOTE: begin
        idx = int'(c.note_index) % NOTE_DEPTH;
        note_start_mem[idx] = ADDR_W'(int'(c.note_start) % SAMPLE_DEPTH);
        note_len_mem[idx] = (c.note_length == '0) ? LEN_W'(1) : c.note_length;
        note_rep_mem[idx] = c.note_repeats;
        if (c.note_period == '0) note_reload_mem[idx] = '0;
        else if (c.note_period > PERIOD_W'(1 << RELOAD_W)) note_reload_mem[idx] = RELOAD_MAX;
        else note_reload_mem[idx] = RELOAD_W'(c.note_period - 1'b1);
        note_known[idx] = 1'b1;
      end
      CMD_EFFECT: begin
        effect_on = 1'b1;
        play_addr = ADDR_W'(int'(c.sample_address) % SAMPLE_DEPTH);
        left_cnt  = c.play_count;
      end
      CMD_MUSIC: begin
        if (c.note_count != '0) begin
          seq_len = (int'(c.note_count) > NOTE_DEPTH) ? NCOUNT_W'(NOTE_DEPTH) : c.note_count;
          music_on  = 1'b1;
          effect_on = 1'b0;
          enter_note(0);
        end
      end
      CMD_STOP: music_on = 1'b0;
      CMD_TICK: begin
        emits = 1'b1;
        if (left_cnt != 0) begin
          o.dac = pull_sample();
          if (left_cnt == 0 && music_on && !effect_on && passes > 1) begin
            passes    = passes - 1'b1;
            play_addr = note_start_mem[note_pos];
            left_cnt  = note_len_mem[note_pos];
          end
        end else if (music_on) begin
          effect_on = 1'b0;
          enter_note((int'(note_pos) + 1) % int'(seq_len));
          o.dac = pull_sample();
        end
        o.reload = cur_reload;
      end
      default: emits = 1'b0;
    endcase
    return emits;
  endfunction

  // Sample address the next tick reads, if it reads one.
  function automatic bit next_fetch(output logic [ADDR_W-1:0] a);
    int p;
    a = play_addr;
    if (left_cnt != 0) return 1'b1;
    if (!music_on) return 1'b0;
    p = (int'(note_pos) + 1) % int'(seq_len);
    a = note_start_mem[p];
    return 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] near_wrap_addr();
    if ($urandom_range(3) == 0) return ADDR_W'($urandom);
    return ADDR_W'((SAMPLE_DEPTH - 32 + $urandom_range(63)) % SAMPLE_DEPTH);
  endfunction

  function automatic seq_row_t random_row(input logic [CMD_W-1:0] cmd);
    seq_row_t r;
    r.cmd            = cmd;
    r.sample_address = near_wrap_addr();
    r.sample_byte    = BYTE_W'($urandom);
    r.play_count     = ($urandom_range(7) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(24));
    r.note_index     = ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(7));
    r.note_start     = near_wrap_addr();
    r.note_length    = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(10));
    r.note_repeats   = ($urandom_range(9) == 0) ? REP_W'($urandom) : REP_W'($urandom_range(4));
    case ($urandom_range(7))
      0: r.note_period = '0;
      1: r.note_period = PERIOD_W'((1 << RELOAD_W) - 1 + $urandom_range(2));
      2: r.note_period = PERIOD_W'($urandom_range(3));
      default: r.note_period = PERIOD_W'($urandom);
    endcase
    r.note_count = ($urandom_range(7) == 0) ? NCOUNT_W'($urandom_range(127, 65))
                                            : NCOUNT_W'($urandom_range(6, 1));
    r.pinned = 1'b0;
    r.dac    = '0;
    r.reload = '0;
    return r;
  endfunction

  task automatic offer(input seq_row_t r);
    tick_out_t o;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid          <= 1'b1;
    in_chan.cmd            <= r.cmd;
    in_chan.sample_address <= r.sample_address;
    in_chan.sample_byte    <= r.sample_byte;
    in_chan.play_count     <= r.play_count;
    in_chan.note_index     <= r.note_index;
    in_chan.note_start     <= r.note_start;
    in_chan.note_length    <= r.note_length;
    in_chan.note_repeats   <= r.note_repeats;
    in_chan.note_period    <= r.note_period;
    in_chan.note_count     <= r.note_count;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    if (play_step(r, o)) begin
      if (r.pinned) begin
        o.dac    = r.dac;
        o.reload = r.reload;
      end
      pending_ticks.push_back(o);
    end
    cmd_tally[r.cmd]++;
    if (r.cmd == CMD_RSVD_6 || r.cmd == CMD_RSVD_7 || (r.cmd == CMD_MUSIC && r.note_count == '0))
      ignored_cnt++;
    else
      useful_cnt++;
  endtask

  // A tick never reads a sample that was never written, so the sample is written first.
  task automatic send_tick();
    seq_row_t r;
    logic [ADDR_W-1:0] a;
    bit fetch;
    r = random_row(CMD_WR_SAMPLE);
    fetch = next_fetch(a);
    if (fetch && !sample_known[a]) begin
      r.sample_address = a;
      offer(r);
    end
    r.cmd = CMD_TICK;
    offer(r);
  endtask

  task automatic random_step();
    seq_row_t r;
    seq_row_t fill;
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_tick();
    end else if (pick < 67) begin
      offer(random_row(CMD_WR_SAMPLE));
    end else if (pick < 77) begin
      offer(random_row(CMD_WR_NOTE));
    end else if (pick < 85) begin
      offer(random_row(CMD_EFFECT));
    end else if (pick < 92) begin
      r = random_row(CMD_MUSIC);
      n = (int'(r.note_count) > NOTE_DEPTH) ? NOTE_DEPTH : int'(r.note_count);
      for (int i = 0; i < n; i++) begin
        if (!note_known[i]) begin
          fill = random_row(CMD_WR_NOTE);
          fill.note_index = IDX_W'(i);
          offer(fill);
        end
      end
      offer(r);
    end else if (pick < 96) begin
      offer(random_row(CMD_STOP));
    end else if (pick < 98) begin
      offer(random_row($urandom_range(1) ? CMD_RSVD_7 : CMD_RSVD_6));
    end else begin
      r = random_row(CMD_MUSIC);
      r.note_count = '0;
      offer(r);
    end
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tick_out_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      results_seen++;
      if (pending_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Unexpected result transfer: dac %0d reload %0d",
                   out_chan.dac_value, out_chan.timer_reload);
      end else begin
        want = pending_ticks.pop_front();
        if (out_chan.dac_value !== want.dac || out_chan.timer_reload !== want.reload) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Result %0d: dac expected %0d got %0d, reload expected %0d got %0d",
                     results_seen, want.dac, out_chan.dac_value, want.reload,
                     out_chan.timer_reload);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    seq_row_t plan [0:25];
    int base;
    in_chan.valid          = 1'b0;
    in_chan.cmd            = CMD_TICK;
    in_chan.sample_address = '0;
    in_chan.sample_byte    = '0;
    in_chan.play_count     = '0;
    in_chan.note_index     = '0;
    in_chan.note_start     = '0;
    in_chan.note_length    = '0;
    in_chan.note_repeats   = '0;
    in_chan.note_period    = '0;
    in_chan.note_count     = '0;
    out_chan.ready         = 1'b0;

    plan[0]  = '{cmd: CMD_TICK, pinned: 1, dac: SILENCE, reload: RELOAD_RESET, default: 0};
    plan[1]  = '{cmd: CMD_RSVD_6, sample_address: 14'h1555, default: 0};
    plan[2]  = '{cmd: CMD_RSVD_7, note_count: 7'h7F, play_count: 15'h7FFF, default: 0};
    plan[3]  = '{cmd: CMD_WR_SAMPLE, sample_address: 14'h3FFF, sample_byte: 8'hFF, default: 0};
    plan[4]  = '{cmd: CMD_WR_SAMPLE, sample_address: 14'h0000, sample_byte: 8'h00, default: 0};
    plan[5]  = '{cmd: CMD_WR_SAMPLE, sample_address: 14'h0001, sample_byte: 8'hA5, default: 0};
    plan[6]  = '{cmd: CMD_EFFECT, sample_address: 14'h3FFF, play_count: 15'd3, default: 0};
    plan[7]  = '{cmd: CMD_TICK, pinned: 1, dac: 12'hFF0, reload: RELOAD_RESET, default: 0};
    plan[8]  = '{cmd: CMD_TICK, pinned: 1, dac: 12'h000, reload: RELOAD_RESET, default: 0};
    plan[9]  = '{cmd: CMD_TICK, pinned: 1, dac: 12'hA50, reload: RELOAD_RESET, default: 0};
    plan[10] = '{cmd: CMD_TICK, pinned: 1, dac: SILENCE, reload: RELOAD_RESET, default: 0};
    plan[11] = '{cmd: CMD_EFFECT, sample_address: 14'h0000, play_count: 15'd0, default: 0};
    plan[12] = '{cmd: CMD_TICK, pinned: 1, dac: SILENCE, reload: RELOAD_RESET, default: 0};
    plan[13] = '{cmd: CMD_WR_NOTE, note_index: 6'd0, note_start: 14'h3FFF, note_length: 15'd0,
                 note_repeats: 16'd0, note_period: 25'd0, default: 0};
    plan[14] = '{cmd: CMD_WR_NOTE, note_index: 6'd1, note_start: 14'h0000, note_length: 15'd2,
                 note_repeats: 16'd2, note_period: 25'h1000001, default: 0};
    plan[15] = '{cmd: CMD_WR_NOTE, note_index: 6'd63, note_start: 14'h3FFF,
                 note_length: 15'h7FFF, note_repeats: 16'hFFFF, note_period: 25'h1FFFFFF,
                 default: 0};
    plan[16] = '{cmd: CMD_MUSIC, note_count: 7'd0, default: 0};
    plan[17] = '{cmd: CMD_TICK, pinned: 1, dac: SILENCE, reload: RELOAD_RESET, default: 0};
    plan[18] = '{cmd: CMD_MUSIC, note_count: 7'd2, default: 0};
    plan[19] = '{cmd: CMD_TICK, pinned: 1, dac: 12'hFF0, reload: 24'd0, default: 0};
    plan[20] = '{cmd: CMD_TICK, pinned: 1, dac: 12'h000, reload: RELOAD_MAX, default: 0};
    plan[21] = '{cmd: CMD_TICK, pinned: 1, dac: 12'hA50, reload: RELOAD_MAX, default: 0};
    plan[22] = '{cmd: CMD_TICK, default: 0};
    plan[23] = '{cmd: CMD_STOP, default: 0};
    plan[24] = '{cmd: CMD_TICK, pinned: 1, dac: 12'hA50, reload: RELOAD_MAX, default: 0};
    plan[25] = '{cmd: CMD_TICK, pinned: 1, dac: SILENCE, reload: RELOAD_MAX, default: 0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer(plan[i]);

    // The receiver holds off while ticks keep coming, so the block backs up and stalls its input.
    hold_asked++;
    repeat (16) send_tick();

    base = useful_cnt;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      while (useful_cnt < base + (ph + 1) * RANDOM_ITEMS / 4) random_step();
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands: %0d ticks, %0d sample writes, %0d note writes,",
             useful_cnt + ignored_cnt, cmd_tally[CMD_TICK], cmd_tally[CMD_WR_SAMPLE],
             cmd_tally[CMD_WR_NOTE]);
    $display("  %0d effects, %0d music starts, %0d stops, %0d ignored; %0d results, %0d bad",
             cmd_tally[CMD_EFFECT], cmd_tally[CMD_MUSIC], cmd_tally[CMD_STOP], ignored_cnt,
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sample_effect_and_note_sequencer_top.f
src/sen_pkg.sv
src/sen_in_if.sv
src/sen_out_if.sv
src/sen_ram.sv
src/sen_front.sv
src/sen_fifo.sv
src/sen_back.sv
src/sample_effect_and_note_sequencer_top.sv
src/sen_checker.sv
verif/tb.sv
